// ===== hdl/cxl_pkg.sv =====
// Shared types and constants for the CoreXY line step interpolator.
`timescale 1ns / 1ps
`default_nettype none

package cxl_pkg;

    // Coordinate format: signed fixed point, FRAC_BITS fraction bits
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TOLERANCE   = 655;

    // Error term widths: full product, and (intercept - y) scaled up
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int SHIFT_WIDTH = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int ERR_WIDTH   = ((PROD_WIDTH > SHIFT_WIDTH) ? PROD_WIDTH : SHIFT_WIDTH) + 1;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SLOPE       = 3'd0,
        CFG_INTERCEPT   = 3'd1,
        CFG_X_STEP_SIZE = 3'd2,
        CFG_Y_STEP_SIZE = 3'd3,
        CFG_DIAG_X_STEP = 3'd4,
        CFG_DIAG_Y_STEP = 3'd5,
        CFG_TARGET_X    = 3'd6,
        CFG_TARGET_Y    = 3'd7
    } cfg_index_t;

    // Request opcodes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t opcode;
        coord_t  load_x;
        coord_t  load_y;
    } in_req_t;

    typedef struct packed {
        logic   step_motor_a;
        logic   step_motor_b;
        logic   dir_motor_a;
        logic   dir_motor_b;
        logic   done_res;
        coord_t cur_x;
        coord_t cur_y;
    } out_res_t;

    typedef struct packed {
        coord_t slope;
        coord_t intercept;
        coord_t x_step_size;
        coord_t y_step_size;
        coord_t diag_x_step;
        coord_t diag_y_step;
        coord_t target_x;
        coord_t target_y;
    } cfg_regs_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        logic   motor_a_dir;
        logic   motor_b_dir;
    } pen_state_t;

endpackage

`default_nettype wire

// ===== hdl/corexy_line_step_interpolator.sv =====
// A taken request waits in the input register and moves on to the result register, which
// raises res_valid, as soon as that register is empty or its result is being taken.
// Throughput: one request per cycle while results are not stalled; the error-compare stage
// updates the pen position as each request moves on; the next one in the input register sees it at once.
// Reset clears position, motor directions, configuration registers and both valid flags.
// Configuration writes take effect at the edge where cfg_we is high.
`timescale 1ns / 1ps
`default_nettype none

module corexy_line_step_interpolator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  cxl_pkg::in_req_t                      req,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output cxl_pkg::out_res_t                     res,
    input  logic                                  cfg_we,
    input  logic [cxl_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [cxl_pkg::COORD_WIDTH-1:0]       cfg_data
);

    cxl_pkg::cfg_regs_t  cfg_reg;
    cxl_pkg::cfg_regs_t  cfg_next;
    cxl_pkg::pen_state_t state_reg;
    cxl_pkg::pen_state_t state_next;
    cxl_pkg::in_req_t    req_reg;
    cxl_pkg::out_res_t   res_reg;
    cxl_pkg::out_res_t   res_next;
    logic                req_valid_reg;
    logic                req_valid_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic                advance;
    logic                req_take;

    // Pipeline control
    assign advance   = req_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Configuration register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cxl_pkg::cfg_index_t'(cfg_index))
                cxl_pkg::CFG_SLOPE:       cfg_next.slope       = cfg_data;
                cxl_pkg::CFG_INTERCEPT:   cfg_next.intercept   = cfg_data;
                cxl_pkg::CFG_X_STEP_SIZE: cfg_next.x_step_size = cfg_data;
                cxl_pkg::CFG_Y_STEP_SIZE: cfg_next.y_step_size = cfg_data;
                cxl_pkg::CFG_DIAG_X_STEP: cfg_next.diag_x_step = cfg_data;
                cxl_pkg::CFG_DIAG_Y_STEP: cfg_next.diag_y_step = cfg_data;
                cxl_pkg::CFG_TARGET_X:    cfg_next.target_x    = cfg_data;
                cxl_pkg::CFG_TARGET_Y:    cfg_next.target_y    = cfg_data;
                default:                  cfg_next             = cfg_reg;
            endcase
        end
    end

    // Step computation
    cxl_step_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req        (req_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            cfg_reg       <= '0;
            state_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
            cfg_reg       <= cfg_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // The shown result always reflects the kept pen state
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.cur_x == state_reg.pos_x)
                       && (res_reg.cur_y == state_reg.pos_y)
                       && (res_reg.dir_motor_a == state_reg.motor_a_dir)
                       && (res_reg.dir_motor_b == state_reg.motor_b_dir))
        else $error("result does not match pen state");

    // Target reached never pulses a motor
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.step_motor_a && !res_reg.step_motor_b)
        else $error("step pulse with done");

    // Input is held off only while a full input stage waits on a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> req_valid_reg && res_valid_reg && res_stall)
        else $error("input stalled without back pressure");

    // A request that moves on leaves a valid result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced request lost");

endmodule

`default_nettype wire

// ===== hdl/cxl_err_mag.sv =====
// Exact magnitude of the line error slope*x - y + intercept, scaled by 2^FRAC_BITS.
`timescale 1ns / 1ps
`default_nettype none

module cxl_err_mag (
    input  cxl_pkg::coord_t                    slope,
    input  cxl_pkg::coord_t                    intercept,
    input  cxl_pkg::coord_t                    x,
    input  cxl_pkg::coord_t                    y,
    output logic [cxl_pkg::ERR_WIDTH-1:0]      err_mag
);

    logic signed [cxl_pkg::PROD_WIDTH-1:0]  prod;
    logic signed [cxl_pkg::COORD_WIDTH:0]   diff;
    logic signed [cxl_pkg::ERR_WIDTH-1:0]   err;
    logic signed [cxl_pkg::ERR_WIDTH-1:0]   err_neg;

    // Full-width product, no rounding
    assign prod = slope * x;

    // intercept - y is exact in one extra bit
    assign diff = (cxl_pkg::COORD_WIDTH+1)'(intercept) - (cxl_pkg::COORD_WIDTH+1)'(y);

    // Sum of product and scaled offset, then absolute value
    assign err     = cxl_pkg::ERR_WIDTH'(prod)
                   + (cxl_pkg::ERR_WIDTH'(diff) <<< cxl_pkg::FRAC_BITS);
    assign err_neg = -err;
    assign err_mag = err[cxl_pkg::ERR_WIDTH-1] ? unsigned'(err_neg) : unsigned'(err);

endmodule

`default_nettype wire

// ===== hdl/cxl_step_core.sv =====
// Next pen position, motor directions and step pulses for one request.
`timescale 1ns / 1ps
`default_nettype none

module cxl_step_core (
    input  cxl_pkg::cfg_regs_t  cfg,
    input  cxl_pkg::pen_state_t state,
    input  cxl_pkg::in_req_t    req,
    output cxl_pkg::pen_state_t state_next,
    output cxl_pkg::out_res_t   res
);

    cxl_pkg::coord_t nx;
    cxl_pkg::coord_t ny;
    cxl_pkg::coord_t dx;
    cxl_pkg::coord_t dy;

    logic signed [cxl_pkg::COORD_WIDTH:0] off_x;
    logic signed [cxl_pkg::COORD_WIDTH:0] off_y;
    logic signed [cxl_pkg::COORD_WIDTH:0] off_x_neg;
    logic signed [cxl_pkg::COORD_WIDTH:0] off_y_neg;
    logic [cxl_pkg::COORD_WIDTH:0]        abs_x;
    logic [cxl_pkg::COORD_WIDTH:0]        abs_y;
    logic                                 near_target;

    logic [cxl_pkg::ERR_WIDTH-1:0] ex;
    logic [cxl_pkg::ERR_WIDTH-1:0] ey;
    logic [cxl_pkg::ERR_WIDTH-1:0] ed;

    logic diag_x_pos;
    logic diag_x_neg;
    logic diag_y_pos;
    logic diag_y_neg;
    logic diag_same;
    logic step_a;
    logic step_b;
    logic done;

    // Candidate positions, wrapping at coordinate width
    assign nx = state.pos_x + cfg.x_step_size;
    assign ny = state.pos_y + cfg.y_step_size;
    assign dx = state.pos_x + cfg.diag_x_step;
    assign dy = state.pos_y + cfg.diag_y_step;

    // Distance to target on each axis
    assign off_x     = (cxl_pkg::COORD_WIDTH+1)'(state.pos_x)
                     - (cxl_pkg::COORD_WIDTH+1)'(cfg.target_x);
    assign off_y     = (cxl_pkg::COORD_WIDTH+1)'(state.pos_y)
                     - (cxl_pkg::COORD_WIDTH+1)'(cfg.target_y);
    assign off_x_neg = -off_x;
    assign off_y_neg = -off_y;
    assign abs_x     = off_x[cxl_pkg::COORD_WIDTH] ? unsigned'(off_x_neg) : unsigned'(off_x);
    assign abs_y     = off_y[cxl_pkg::COORD_WIDTH] ? unsigned'(off_y_neg) : unsigned'(off_y);
    assign near_target = (abs_x < (cxl_pkg::COORD_WIDTH+1)'(cxl_pkg::TOLERANCE))
                      && (abs_y < (cxl_pkg::COORD_WIDTH+1)'(cxl_pkg::TOLERANCE));

    // Error of the three candidate steps
    cxl_err_mag u_err_x (
        .slope     (cfg.slope),
        .intercept (cfg.intercept),
        .x         (nx),
        .y         (state.pos_y),
        .err_mag   (ex)
    );

    cxl_err_mag u_err_y (
        .slope     (cfg.slope),
        .intercept (cfg.intercept),
        .x         (state.pos_x),
        .y         (ny),
        .err_mag   (ey)
    );

    cxl_err_mag u_err_d (
        .slope     (cfg.slope),
        .intercept (cfg.intercept),
        .x         (dx),
        .y         (dy),
        .err_mag   (ed)
    );

    // Diagonal sign classes pick the motor
    assign diag_x_neg = cfg.diag_x_step[cxl_pkg::COORD_WIDTH-1];
    assign diag_y_neg = cfg.diag_y_step[cxl_pkg::COORD_WIDTH-1];
    assign diag_x_pos = !diag_x_neg && (cfg.diag_x_step != '0);
    assign diag_y_pos = !diag_y_neg && (cfg.diag_y_step != '0);
    assign diag_same  = (diag_x_pos && diag_y_pos) || (diag_x_neg && diag_y_neg);

    // Move selection
    always_comb
    begin
        state_next = state;
        step_a     = 1'b0;
        step_b     = 1'b0;
        done       = 1'b0;
        if (req.opcode == cxl_pkg::OP_LOAD)
        begin
            state_next.pos_x = req.load_x;
            state_next.pos_y = req.load_y;
        end
        else if (near_target)
        begin
            state_next.pos_x = cfg.target_x;
            state_next.pos_y = cfg.target_y;
            done             = 1'b1;
        end
        else if (cfg.x_step_size == '0)
        begin
            state_next.pos_y = ny;
            step_a           = 1'b1;
            step_b           = 1'b1;
        end
        else if (cfg.y_step_size == '0)
        begin
            state_next.pos_x = nx;
            step_a           = 1'b1;
            step_b           = 1'b1;
        end
        else if ((ed < ex) && (ed < ey))
        begin
            if (diag_same)
            begin
                state_next.motor_a_dir = diag_x_pos;
                step_a                 = 1'b1;
            end
            else
            begin
                state_next.motor_b_dir = diag_x_pos;
                step_b                 = 1'b1;
            end
            state_next.pos_x = dx;
            state_next.pos_y = dy;
        end
        else if ((ex < ed) && (ex < ey))
        begin
            state_next.pos_x       = nx;
            state_next.motor_a_dir = !cfg.x_step_size[cxl_pkg::COORD_WIDTH-1];
            state_next.motor_b_dir = cfg.x_step_size[cxl_pkg::COORD_WIDTH-1];
            step_a                 = 1'b1;
            step_b                 = 1'b1;
        end
        else if ((ey < ed) && (ey < ex))
        begin
            state_next.pos_y       = ny;
            state_next.motor_a_dir = !cfg.y_step_size[cxl_pkg::COORD_WIDTH-1];
            state_next.motor_b_dir = !cfg.y_step_size[cxl_pkg::COORD_WIDTH-1];
            step_a                 = 1'b1;
            step_b                 = 1'b1;
        end
    end

    // Result is the state after this request
    assign res.step_motor_a = step_a;
    assign res.step_motor_b = step_b;
    assign res.dir_motor_a  = state_next.motor_a_dir;
    assign res.dir_motor_b  = state_next.motor_b_dir;
    assign res.done_res     = done;
    assign res.cur_x        = state_next.pos_x;
    assign res.cur_y        = state_next.pos_y;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the CoreXY line step interpolator: table-driven and random requests vs a predictor.
`timescale 1ns / 1ps

module tb;
    import cxl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQS     = 48;
    localparam int IDLE_PCT       = 34;
    localparam int QUIET_PHASE    = 5;
    localparam int ONE            = 1 << FRAC_BITS;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        cfg_index_t index;
        coord_t     data;
        in_req_t    r;
        logic       has_exp;
        out_res_t   exp;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    in_req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    out_res_t res;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [COORD_WIDTH-1:0] cfg_data = '0;

    // Expectation attached to the request on the bus (typed-in rows only)
    logic req_has_exp = 1'b0;
    out_res_t req_exp = '0;

    // Predictor state: configuration, pen position, kept motor directions
    cfg_regs_t line_cfg = '0;
    coord_t pen_x = '0;
    coord_t pen_y = '0;
    logic dir_a = 1'b0;
    logic dir_b = 1'b0;

    out_res_t pending_q[$];
    plan_row_t plan_q[$];
    int req_count = 0;
    int res_count = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int idle_pct = IDLE_PCT;
    out_res_t predicted;
    out_res_t oldest;

    corexy_line_step_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Magnitude of slope*X - Y + intercept, scaled by 2^FRAC_BITS, exact
    function automatic logic [71:0] line_error(coord_t x, coord_t y);
        logic signed [71:0] m, b, px, py, e;
        m = $signed(line_cfg.slope);
        b = $signed(line_cfg.intercept);
        px = x;
        py = y;
        e = m * px + ((b - py) <<< FRAC_BITS);
        return (e < 0) ? -e : e;
    endfunction

    function automatic logic near(coord_t a, coord_t t);
        longint d;
        d = longint'(a) - longint'(t);
        return (d < TOLERANCE) && (d > -TOLERANCE);
    endfunction

    // Advance the pen model by one request and return the result it gives
    function automatic out_res_t advance_pen(in_req_t r);
        out_res_t o;
        coord_t nx, ny, dx, dy;
        logic [71:0] ex, ey, ed;
        logic sa, sb, dn, same;
        sa = 1'b0;
        sb = 1'b0;
        dn = 1'b0;
        if (r.opcode == OP_LOAD)
        begin
            pen_x = r.load_x;
            pen_y = r.load_y;
        end
        else if (near(pen_x, line_cfg.target_x) && near(pen_y, line_cfg.target_y))
        begin
            pen_x = line_cfg.target_x;
            pen_y = line_cfg.target_y;
            dn = 1'b1;
        end
        else if (line_cfg.x_step_size == 0)
        begin
            pen_y = pen_y + line_cfg.y_step_size;
            sa = 1'b1;
            sb = 1'b1;
        end
        else if (line_cfg.y_step_size == 0)
        begin
            pen_x = pen_x + line_cfg.x_step_size;
            sa = 1'b1;
            sb = 1'b1;
        end
        else
        begin
            nx = pen_x + line_cfg.x_step_size;
            ny = pen_y + line_cfg.y_step_size;
            dx = pen_x + line_cfg.diag_x_step;
            dy = pen_y + line_cfg.diag_y_step;
            ex = line_error(nx, pen_y);
            ey = line_error(pen_x, ny);
            ed = line_error(dx, dy);
            if (ed < ex && ed < ey)
            begin
                // same-sign diagonal runs on belt A alone, mixed signs on belt B
                same = ($signed(line_cfg.diag_x_step) > 0 && $signed(line_cfg.diag_y_step) > 0) ||
                       ($signed(line_cfg.diag_x_step) < 0 && $signed(line_cfg.diag_y_step) < 0);
                if (same)
                begin
                    dir_a = $signed(line_cfg.diag_x_step) > 0;
                    sa = 1'b1;
                end
                else
                begin
                    dir_b = $signed(line_cfg.diag_x_step) > 0;
                    sb = 1'b1;
                end
                pen_x = dx;
                pen_y = dy;
            end
            else if (ex < ed && ex < ey)
            begin
                pen_x = nx;
                dir_a = $signed(line_cfg.x_step_size) > 0;
                dir_b = !dir_a;
                sa = 1'b1;
                sb = 1'b1;
            end
            else if (ey < ed && ey < ex)
            begin
                pen_y = ny;
                dir_a = $signed(line_cfg.y_step_size) > 0;
                dir_b = dir_a;
                sa = 1'b1;
                sb = 1'b1;
            end
        end
        o.step_motor_a = sa;
        o.step_motor_b = sb;
        o.dir_motor_a = dir_a;
        o.dir_motor_b = dir_b;
        o.done_res = dn;
        o.cur_x = pen_x;
        o.cur_y = pen_y;
        return o;
    endfunction

    function automatic out_res_t pen_result(logic sa, logic sb, logic da, logic db, logic dn,
                                            coord_t x, coord_t y);
        out_res_t o;
        o.step_motor_a = sa;
        o.step_motor_b = sb;
        o.dir_motor_a = da;
        o.dir_motor_b = db;
        o.done_res = dn;
        o.cur_x = x;
        o.cur_y = y;
        return o;
    endfunction

    function automatic void plan_cfg(cfg_index_t idx, coord_t value);
        plan_row_t row;
        row.kind = ROW_CFG;
        row.index = idx;
        row.data = value;
        row.r = '0;
        row.has_exp = 1'b0;
        row.exp = '0;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_req(opcode_t op, coord_t x, coord_t y, logic has_exp,
                                     out_res_t exp);
        plan_row_t row;
        row.kind = ROW_REQ;
        row.index = CFG_SLOPE;
        row.data = '0;
        row.r.opcode = op;
        row.r.load_x = x;
        row.r.load_y = y;
        row.has_exp = has_exp;
        row.exp = exp;
        plan_q.push_back(row);
    endfunction

    function automatic coord_t small_coord(int unsigned lim);
        return coord_t'(int'($urandom_range(2 * lim)) - int'(lim));
    endfunction

    function automatic coord_t extreme_coord();
        coord_t v;
        case ($urandom_range(5))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '0;
            3: v = 32'h0000_0001;
            4: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Axis step of up to two units, zero now and then for pure moves
    function automatic coord_t axis_step();
        return ($urandom_range(5) == 0) ? coord_t'(0) : small_coord(2 * ONE);
    endfunction

    function automatic in_req_t random_req();
        in_req_t r;
        r.opcode = ($urandom_range(9) == 0) ? OP_LOAD : OP_TICK;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
            begin
                // close to the target, straddling the tolerance window
                r.load_x = line_cfg.target_x + small_coord(TOLERANCE + 150);
                r.load_y = line_cfg.target_y + small_coord(TOLERANCE + 150);
            end
            5, 6, 7:
            begin
                r.load_x = small_coord(64 * ONE);
                r.load_y = small_coord(64 * ONE);
            end
            default:
            begin
                r.load_x = $urandom;
                r.load_y = $urandom;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH result %0d: %s", res_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Present one request and hold it until it is taken
    task automatic send_req(in_req_t r, logic has_exp, out_res_t exp);
        int sent;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= r;
        req_has_exp <= has_exp;
        req_exp <= exp;
        req_valid <= 1'b1;
        sent = req_count;
        do
            @(negedge clk);
        while (req_count == sent);
    endtask

    // Stop requesting and wait for the pipeline to empty
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Caller lowers cfg_we after the last write of a batch
    task automatic write_reg(cfg_index_t idx, coord_t value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SLOPE:       line_cfg.slope = value;
            CFG_INTERCEPT:   line_cfg.intercept = value;
            CFG_X_STEP_SIZE: line_cfg.x_step_size = value;
            CFG_Y_STEP_SIZE: line_cfg.y_step_size = value;
            CFG_DIAG_X_STEP: line_cfg.diag_x_step = value;
            CFG_DIAG_Y_STEP: line_cfg.diag_y_step = value;
            CFG_TARGET_X:    line_cfg.target_x = value;
            CFG_TARGET_Y:    line_cfg.target_y = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Result side stalls at random
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < idle_pct);

    // Scoreboard: check results first, then predict newly taken requests
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            if (pending_q.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                oldest = pending_q.pop_front();
                check_field("step_motor_a", res.step_motor_a, oldest.step_motor_a);
                check_field("step_motor_b", res.step_motor_b, oldest.step_motor_b);
                check_field("dir_motor_a", res.dir_motor_a, oldest.dir_motor_a);
                check_field("dir_motor_b", res.dir_motor_b, oldest.dir_motor_b);
                check_field("done_res", res.done_res, oldest.done_res);
                check_field("cur_x", res.cur_x, oldest.cur_x);
                check_field("cur_y", res.cur_y, oldest.cur_y);
            end
            res_count++;
        end
        if (req_valid && !req_stall)
        begin
            predicted = advance_pen(req);
            pending_q.push_back(req_has_exp ? req_exp : predicted);
            req_count++;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        plan_row_t row;
        cfg_regs_t c;
        logic extreme;
        logic writing;

        // Directed table; typed expectations where the outcome is obvious
        plan_req(OP_TICK, 0, 0, 1'b1, pen_result(0, 0, 0, 0, 1, 0, 0));
        plan_req(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                 pen_result(0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        plan_req(OP_TICK, 0, 0, 1'b1, pen_result(1, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        // pure y move up from the most negative y
        plan_cfg(CFG_Y_STEP_SIZE, 32'h7FFF_FFFF);
        plan_req(OP_TICK, 0, 0, 1'b1, pen_result(1, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // pure x move by the most negative step
        plan_cfg(CFG_X_STEP_SIZE, 32'h8000_0000);
        plan_cfg(CFG_Y_STEP_SIZE, 0);
        plan_req(OP_TICK, 0, 0, 1'b1, pen_result(1, 1, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // just inside tolerance on both axes: snap to target
        plan_cfg(CFG_TARGET_X, TOLERANCE - 2);
        plan_cfg(CFG_TARGET_Y, -TOLERANCE);
        plan_req(OP_TICK, 0, 0, 1'b1, pen_result(0, 0, 0, 0, 1, TOLERANCE - 2, -TOLERANCE));
        // exactly TOLERANCE away: no snap, pure x move instead
        plan_req(OP_LOAD, -2, 0, 1'b1, pen_result(0, 0, 0, 0, 0, -2, 0));
        plan_req(OP_TICK, 0, 0, 1'b1, pen_result(1, 1, 0, 0, 0, 32'h7FFF_FFFE, 0));
        // unit line y = x, diagonal in both positive directions
        plan_cfg(CFG_SLOPE, ONE);
        plan_cfg(CFG_INTERCEPT, 0);
        plan_cfg(CFG_X_STEP_SIZE, ONE);
        plan_cfg(CFG_Y_STEP_SIZE, ONE);
        plan_cfg(CFG_DIAG_X_STEP, ONE);
        plan_cfg(CFG_DIAG_Y_STEP, ONE);
        plan_cfg(CFG_TARGET_X, 32'h7FFF_0000);
        plan_cfg(CFG_TARGET_Y, 32'h7FFF_0000);
        plan_req(OP_LOAD, 0, 0, 1'b0, '0);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);
        // diagonal with both increments negative
        plan_cfg(CFG_DIAG_X_STEP, -ONE);
        plan_cfg(CFG_DIAG_Y_STEP, -ONE);
        plan_req(OP_LOAD, 0, 0, 1'b0, '0);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);
        // mixed-sign diagonal on a falling line
        plan_cfg(CFG_SLOPE, -ONE);
        plan_cfg(CFG_DIAG_X_STEP, ONE);
        plan_cfg(CFG_DIAG_Y_STEP, -ONE);
        plan_req(OP_LOAD, 0, 0, 1'b0, '0);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);
        // x and y tie: no move at all
        plan_cfg(CFG_SLOPE, ONE);
        plan_req(OP_LOAD, 0, 0, 1'b0, '0);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);
        // steep line: y step wins
        plan_cfg(CFG_SLOPE, 2 * ONE);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);
        // shallow line: x step wins
        plan_cfg(CFG_SLOPE, ONE / 2);
        plan_req(OP_LOAD, 0, 0, 1'b0, '0);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);
        // most negative slope and intercept at the corners
        plan_cfg(CFG_SLOPE, 32'h8000_0000);
        plan_cfg(CFG_INTERCEPT, 32'h8000_0000);
        plan_req(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
        plan_req(OP_TICK, 0, 0, 1'b0, '0);

        // Reset
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        writing = 1'b0;
        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.kind == ROW_CFG)
            begin
                if (!writing)
                    settle();
                write_reg(row.index, row.data);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    cfg_we <= 1'b0;
                writing = 1'b0;
                send_req(row.r, row.has_exp, row.exp);
            end
        end

        // Random phases, each with a fresh line setup
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
            extreme = (p % 4 == 3);
            if (extreme)
            begin
                c.slope = extreme_coord();
                c.intercept = extreme_coord();
                c.x_step_size = extreme_coord();
                c.y_step_size = extreme_coord();
                c.diag_x_step = extreme_coord();
                c.diag_y_step = extreme_coord();
                c.target_x = extreme_coord();
                c.target_y = extreme_coord();
            end
            else
            begin
                c.slope = small_coord(4 * ONE);
                c.intercept = small_coord(8 * ONE);
                c.x_step_size = axis_step();
                c.y_step_size = axis_step();
                if ($urandom_range(1) == 0)
                begin
                    c.diag_x_step = c.x_step_size;
                    c.diag_y_step = c.y_step_size;
                end
                else
                begin
                    c.diag_x_step = small_coord(2 * ONE);
                    c.diag_y_step = small_coord(2 * ONE);
                end
                c.target_x = small_coord(64 * ONE);
                c.target_y = small_coord(64 * ONE);
            end
            write_reg(CFG_SLOPE, c.slope);
            write_reg(CFG_INTERCEPT, c.intercept);
            write_reg(CFG_X_STEP_SIZE, c.x_step_size);
            write_reg(CFG_Y_STEP_SIZE, c.y_step_size);
            write_reg(CFG_DIAG_X_STEP, c.diag_x_step);
            write_reg(CFG_DIAG_Y_STEP, c.diag_y_step);
            write_reg(CFG_TARGET_X, c.target_x);
            write_reg(CFG_TARGET_Y, c.target_y);
            cfg_we <= 1'b0;
            for (int i = 0; i < PHASE_REQS; i++)
                send_req(random_req(), 1'b0, '0);
        end

        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== corexy_line_step_interpolator.f =====
hdl/cxl_pkg.sv
hdl/cxl_err_mag.sv
hdl/cxl_step_core.sv
hdl/corexy_line_step_interpolator.sv
bench/tb.sv
